[rtl/core/periodic_waveform_generator_defines.svh]
// assertion helpers for the periodic waveform generator
`ifndef PERIODIC_WAVEFORM_GENERATOR_DEFINES_SVH
`define PERIODIC_WAVEFORM_GENERATOR_DEFINES_SVH

// same-cycle implication, checked out of reset
`define PWG_ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked out of reset
`define PWG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/core/pwg_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pwg_pkg
// Shared widths, codes and types of the periodic waveform generator.
// ----------------------------------------------------------------------------
package pwg_pkg;

  localparam int TIME_W     = 32;
  localparam int TSUM_W     = 33;
  localparam int RATE_W     = 32;
  localparam int LEVEL_W    = 24;
  localparam int SAMPLE_W   = 25;
  localparam int KIND_W     = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int SHAPE_W    = 18;
  localparam int PROD_W     = SHAPE_W + LEVEL_W;

  localparam logic [KIND_W-1:0] KIND_IDENTITY = 3'd0;
  localparam logic [KIND_W-1:0] KIND_CONSTANT = 3'd1;
  localparam logic [KIND_W-1:0] KIND_SQUARE   = 3'd2;
  localparam logic [KIND_W-1:0] KIND_SAWTOOTH = 3'd3;
  localparam logic [KIND_W-1:0] KIND_TRIANGLE = 3'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_WAVE_KIND  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_LEVEL = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_AMPLITUDE  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PHASE      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_RATE       = 3'd4;

  // 1.0 in q.16
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_ONE = 25'sd65536;

  typedef logic signed [SHAPE_W-1:0] shape_t;
  typedef logic signed [PROD_W-1:0]  prod_t;

endpackage
`default_nettype wire

[rtl/core/pwg_shape.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pwg_shape
// Two-stage cycle position and unit shape: split multiply, then fold.
// ----------------------------------------------------------------------------
module pwg_shape (
  input  wire                            clk,
  input  wire                            rst_n,
  input  wire                            in_valid,
  output logic                           in_stall,
  input  wire  [pwg_pkg::TSUM_W-1:0]     t_sum,
  input  wire  [pwg_pkg::RATE_W-1:0]     rate,
  input  wire  [pwg_pkg::KIND_W-1:0]     kind,
  output logic                           out_valid,
  input  wire                            out_stall,
  output pwg_pkg::shape_t                shape
);

  logic [48:0] prod_lo;
  logic [32:0] prod_hi;
  logic        va_r;
  logic [16:0] p_lo_r;
  logic [16:0] p_hi_r;
  logic        vb_r;
  pwg_pkg::shape_t shape_r;
  pwg_pkg::shape_t shape_nxt;
  logic        en_a;
  logic        en_b;
  logic [16:0] pos;
  logic [17:0] two_f;
  logic [17:0] tri_y;
  logic [18:0] tri_2y;
  logic [17:0] saw_s;
  logic [18:0] tri_s;

  // rate split in halves; only position bits 32..16 matter
  assign prod_lo = {16'b0, t_sum} * {33'b0, rate[15:0]};
  assign prod_hi = {16'b0, t_sum[16:0]} * {17'b0, rate[31:16]};

  assign en_b     = !vb_r || !out_stall;
  assign en_a     = !va_r || en_b;
  assign in_stall = !en_a;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
    end else begin
      if (en_a) begin
        va_r <= in_valid;
      end
      if (en_b) begin
        vb_r <= va_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en_a && in_valid) begin
      p_lo_r <= prod_lo[32:16];
      p_hi_r <= prod_hi[16:0];
    end
    if (en_b && va_r) begin
      shape_r <= shape_nxt;
    end
  end

  always_comb begin
    pos    = p_lo_r + p_hi_r;
    two_f  = {1'b0, pos[15:0], 1'b0};
    saw_s  = two_f - 18'd65536;
    // triangle folds above one half
    tri_y  = (two_f > 18'd65536) ? (18'd131072 - two_f) : two_f;
    tri_2y = {tri_y, 1'b0};
    tri_s  = tri_2y - 19'd65536;
    case (kind)
      pwg_pkg::KIND_SQUARE: begin
        shape_nxt = pos[16] ? -18'sd65536 : 18'sd65536;
      end
      pwg_pkg::KIND_SAWTOOTH: begin
        shape_nxt = pwg_pkg::shape_t'(saw_s);
      end
      pwg_pkg::KIND_TRIANGLE: begin
        shape_nxt = pwg_pkg::shape_t'(tri_s[17:0]);
      end
      default: begin
        shape_nxt = '0;
      end
    endcase
  end

  assign out_valid = vb_r;
  assign shape     = shape_r;

endmodule
`default_nettype wire

[rtl/core/periodic_waveform_generator.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// periodic_waveform_generator
// Identity, constant, square, sawtooth and triangle samples from a time value.
// ----------------------------------------------------------------------------
// Takes one sample time per clock and returns one q9.16 sample per clock
// while the output is not stalled. The stages are: time plus phase, the
// two halves of the split rate multiply, shape folding, shape times
// amplitude, and rounding plus base with the kind select. Each stage holds
// its own valid bit, so a stall on the output fills empty stages before
// pushing back on the input.
// Registers are written through cfg_we/cfg_index/cfg_data and must only be
// changed while no item is in flight.
module periodic_waveform_generator (
  input  wire                                   clk,
  input  wire                                   rst_n,
  input  wire                                   in_valid,
  output logic                                  in_stall,
  input  wire  [pwg_pkg::TIME_W-1:0]            in_sample_time,
  output logic                                  out_valid,
  input  wire                                   out_stall,
  output logic signed [pwg_pkg::SAMPLE_W-1:0]   out_sample_value,
  input  wire                                   cfg_we,
  input  wire  [pwg_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  wire  [pwg_pkg::CFG_DATA_W-1:0]        cfg_data
);

  logic [pwg_pkg::KIND_W-1:0]          kind_r;
  logic signed [pwg_pkg::LEVEL_W-1:0]  base_r;
  logic signed [pwg_pkg::LEVEL_W-1:0]  amp_r;
  logic [pwg_pkg::TIME_W-1:0]          phase_r;
  logic [pwg_pkg::RATE_W-1:0]          rate_r;

  logic                                v1_r;
  logic [pwg_pkg::TSUM_W-1:0]          t_r;
  logic                                sh_in_stall;
  logic                                sh_valid;
  pwg_pkg::shape_t                     sh_shape;
  logic                                v3_r;
  pwg_pkg::prod_t                      prod_r;
  logic                                out_valid_r;
  logic signed [pwg_pkg::SAMPLE_W-1:0] out_value_r;
  logic signed [pwg_pkg::SAMPLE_W-1:0] out_value_nxt;
  pwg_pkg::prod_t                      rounded;
  logic signed [pwg_pkg::SAMPLE_W-1:0] base_ext;
  logic signed [pwg_pkg::SAMPLE_W-1:0] wave_sum;
  logic                                en1;
  logic                                en3;
  logic                                en4;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kind_r  <= '0;
      base_r  <= '0;
      amp_r   <= '0;
      phase_r <= '0;
      rate_r  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        pwg_pkg::CFG_WAVE_KIND:  kind_r  <= cfg_data[pwg_pkg::KIND_W-1:0];
        pwg_pkg::CFG_BASE_LEVEL: base_r  <= cfg_data[pwg_pkg::LEVEL_W-1:0];
        pwg_pkg::CFG_AMPLITUDE:  amp_r   <= cfg_data[pwg_pkg::LEVEL_W-1:0];
        pwg_pkg::CFG_PHASE:      phase_r <= cfg_data[pwg_pkg::TIME_W-1:0];
        pwg_pkg::CFG_RATE:       rate_r  <= cfg_data[pwg_pkg::RATE_W-1:0];
        default: ;
      endcase
    end
  end

  assign en4      = !out_valid_r || !out_stall;
  assign en3      = !v3_r || en4;
  assign en1      = !v1_r || !sh_in_stall;
  assign in_stall = !en1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v3_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (en1) begin
        v1_r <= in_valid;
      end
      if (en3) begin
        v3_r <= sh_valid;
      end
      if (en4) begin
        out_valid_r <= v3_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en1 && in_valid) begin
      t_r <= {1'b0, in_sample_time} + {1'b0, phase_r};
    end
    if (en3 && sh_valid) begin
      prod_r <= pwg_pkg::prod_t'(sh_shape) * pwg_pkg::prod_t'(amp_r);
    end
    if (en4 && v3_r) begin
      out_value_r <= out_value_nxt;
    end
  end

  pwg_shape u_shape (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (v1_r),
    .in_stall  (sh_in_stall),
    .t_sum     (t_r),
    .rate      (rate_r),
    .kind      (kind_r),
    .out_valid (sh_valid),
    .out_stall (!en3),
    .shape     (sh_shape)
  );

  always_comb begin
    // round half up back to q.16
    rounded  = (prod_r + pwg_pkg::prod_t'(32768)) >>> 16;
    base_ext = {base_r[pwg_pkg::LEVEL_W-1], base_r};
    wave_sum = base_ext + rounded[pwg_pkg::SAMPLE_W-1:0];
    case (kind_r)
      pwg_pkg::KIND_IDENTITY: begin
        out_value_nxt = pwg_pkg::SAMPLE_ONE;
      end
      pwg_pkg::KIND_CONSTANT: begin
        out_value_nxt = base_ext;
      end
      pwg_pkg::KIND_SQUARE, pwg_pkg::KIND_SAWTOOTH, pwg_pkg::KIND_TRIANGLE: begin
        out_value_nxt = (rate_r == '0) ? pwg_pkg::SAMPLE_ONE : wave_sum;
      end
      default: begin
        out_value_nxt = base_ext;
      end
    endcase
  end

  assign out_valid        = out_valid_r;
  assign out_sample_value = out_value_r;

endmodule
`default_nettype wire

[rtl/core/pwg_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pwg_checker
// Port-level checks of the periodic waveform generator, bound to the top.
// ----------------------------------------------------------------------------
`include "periodic_waveform_generator_defines.svh"

module pwg_checker (
  input wire                                 clk,
  input wire                                 rst_n,
  input wire                                 out_valid,
  input wire                                 out_stall,
  input wire [pwg_pkg::SAMPLE_W-1:0]         out_sample_value,
  input wire                                 cfg_we,
  input wire [pwg_pkg::CFG_IDX_W-1:0]        cfg_index,
  input wire [pwg_pkg::CFG_DATA_W-1:0]       cfg_data
);

  logic [pwg_pkg::KIND_W-1:0]  kind_r;
  logic [pwg_pkg::LEVEL_W-1:0] base_r;
  logic                        is_identity;
  logic                        is_constant;
  logic                        id_ok;
  logic                        const_ok;

  // shadow of the two registers that fix the output outright
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kind_r <= '0;
      base_r <= '0;
    end else if (cfg_we) begin
      if (cfg_index == pwg_pkg::CFG_WAVE_KIND) begin
        kind_r <= cfg_data[pwg_pkg::KIND_W-1:0];
      end
      if (cfg_index == pwg_pkg::CFG_BASE_LEVEL) begin
        base_r <= cfg_data[pwg_pkg::LEVEL_W-1:0];
      end
    end
  end

  assign is_identity = (kind_r == pwg_pkg::KIND_IDENTITY);
  assign is_constant = (kind_r == pwg_pkg::KIND_CONSTANT);
  assign id_ok       = (out_sample_value == pwg_pkg::SAMPLE_ONE);
  assign const_ok    = (out_sample_value == {base_r[pwg_pkg::LEVEL_W-1], base_r});

  `PWG_ASSERT_NEXT(a_hold_valid, out_valid && out_stall, out_valid, "out item dropped")
  `PWG_ASSERT_NEXT(a_hold_data, out_valid && out_stall, $stable(out_sample_value), "item changed")
  `PWG_ASSERT_IMPLIES(a_reset_empty, !$past(rst_n), !out_valid, "item out of reset")
  `PWG_ASSERT_IMPLIES(a_identity, out_valid && is_identity, id_ok, "identity not one")
  `PWG_ASSERT_IMPLIES(a_constant, out_valid && is_constant, const_ok, "constant not base")

endmodule

bind periodic_waveform_generator pwg_checker u_pwg_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_sample_value (out_sample_value),
  .cfg_we           (cfg_we),
  .cfg_index        (cfg_index),
  .cfg_data         (cfg_data)
);
`default_nettype wire

[tb/sv/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the periodic waveform generator.
// ----------------------------------------------------------------------------
// Sample times go in through the valid/stall input channel and every sample
// that comes out is compared with a bit-exact prediction computed from the
// bench's own copy of the waveform registers. A directed pass covers each
// wave kind, the zero-rate and unused-kind cases and the extremes of times,
// levels and rates. Random passes follow under four idling mixes on the two
// channels, each pass moving through several random waveform settings.
// ----------------------------------------------------------------------------
module tb;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 8;
  localparam longint UNIT_Q16 = 64'sd65536;
  localparam logic [pwg_pkg::KIND_W-1:0] KIND_LAST_UNUSED = 3'd7;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic [pwg_pkg::TIME_W-1:0] in_sample_time;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [pwg_pkg::SAMPLE_W-1:0] out_sample_value;
  logic cfg_we;
  logic [pwg_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [pwg_pkg::CFG_DATA_W-1:0] cfg_data;

  // bench copy of the waveform registers
  logic [pwg_pkg::KIND_W-1:0] kind_cfg;
  logic signed [pwg_pkg::LEVEL_W-1:0] base_cfg;
  logic signed [pwg_pkg::LEVEL_W-1:0] amp_cfg;
  logic [pwg_pkg::TIME_W-1:0] phase_cfg;
  logic [pwg_pkg::RATE_W-1:0] rate_cfg;

  logic [pwg_pkg::SAMPLE_W-1:0] expected_samples[$];
  int mismatch_count = 0;
  int idle_pct = 0;
  int stall_pct = 0;
  int quiet_cycles = 0;

  periodic_waveform_generator u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_sample_time   (in_sample_time),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_sample_value (out_sample_value),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  function automatic logic [pwg_pkg::SAMPLE_W-1:0] predict_sample(
      input logic [pwg_pkg::TIME_W-1:0] t);
    logic [pwg_pkg::TSUM_W-1:0] tsum;
    logic [64:0] pos;
    longint base;
    longint amp;
    longint frac;
    longint y;
    longint shape;
    longint res;
    tsum = {1'b0, t} + {1'b0, phase_cfg};
    pos = {32'b0, tsum} * {33'b0, rate_cfg};
    base = longint'(base_cfg);
    amp = longint'(amp_cfg);
    frac = longint'(pos[31:16]);
    case (kind_cfg)
      pwg_pkg::KIND_IDENTITY: res = UNIT_Q16;
      pwg_pkg::KIND_CONSTANT: res = base;
      pwg_pkg::KIND_SQUARE: begin
        if (rate_cfg == 0) res = UNIT_Q16;
        else res = pos[32] ? base - amp : base + amp;
      end
      pwg_pkg::KIND_SAWTOOTH, pwg_pkg::KIND_TRIANGLE: begin
        if (rate_cfg == 0) begin
          res = UNIT_Q16;
        end else begin
          y = 2 * frac;
          // triangle folds back down over the second half cycle
          if (kind_cfg == pwg_pkg::KIND_TRIANGLE && y > UNIT_Q16) y = 2 * UNIT_Q16 - y;
          shape = (kind_cfg == pwg_pkg::KIND_TRIANGLE) ? 2 * y - UNIT_Q16 : y - UNIT_Q16;
          // round half up back to q.16
          res = base + ((shape * amp + 32768) >>> 16);
        end
      end
      default: res = base;
    endcase
    return res[pwg_pkg::SAMPLE_W-1:0];
  endfunction

  task automatic report_mismatch(input string what,
                                 input logic [pwg_pkg::SAMPLE_W-1:0] got,
                                 input logic [pwg_pkg::SAMPLE_W-1:0] want);
    $display("%0t: %s: got %h, expected %h", $time, what, got, want);
    mismatch_count++;
  endtask

  // result checker
  always @(posedge clk) begin
    logic [pwg_pkg::SAMPLE_W-1:0] want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_samples.size() == 0) begin
        report_mismatch("sample with no item pending", out_sample_value, '0);
      end else begin
        want = expected_samples.pop_front();
        if (out_sample_value !== want) report_mismatch("sample_value", out_sample_value, want);
      end
    end
  end

  // watchdog on cycles with no handshake on either channel
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: timeout, %0d samples pending", $time, expected_samples.size());
        $display("Mismatches found");
        $finish;
      end
    end
  end

  task automatic send_time(input logic [pwg_pkg::TIME_W-1:0] t);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_sample_time <= t;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_samples.push_back(predict_sample(t));
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_samples.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [pwg_pkg::CFG_IDX_W-1:0] idx,
                           input logic [pwg_pkg::CFG_DATA_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
  endtask

  // upper bits beyond each register's width carry junk that must be ignored
  task automatic set_waveform(input logic [pwg_pkg::KIND_W-1:0] kind,
                              input logic [pwg_pkg::LEVEL_W-1:0] base,
                              input logic [pwg_pkg::LEVEL_W-1:0] amp,
                              input logic [pwg_pkg::TIME_W-1:0] phase,
                              input logic [pwg_pkg::RATE_W-1:0] rate);
    logic [31:0] junk;
    junk = $urandom;
    wait_drained();
    write_reg(pwg_pkg::CFG_WAVE_KIND, {junk[31:3], kind});
    write_reg(pwg_pkg::CFG_BASE_LEVEL, {junk[31:24], base});
    write_reg(pwg_pkg::CFG_AMPLITUDE, {junk[23:16], amp});
    write_reg(pwg_pkg::CFG_PHASE, phase);
    write_reg(pwg_pkg::CFG_RATE, rate);
    cfg_we <= 1'b0;
    kind_cfg = kind;
    base_cfg = base;
    amp_cfg = amp;
    phase_cfg = phase;
    rate_cfg = rate;
  endtask

  function automatic logic [pwg_pkg::LEVEL_W-1:0] pick_level();
    logic [31:0] r;
    r = $urandom;
    case ($urandom_range(7))
      0: return 24'h7FFFFF;
      1: return 24'h800000;
      2: return 24'h000000;
      default: return r[pwg_pkg::LEVEL_W-1:0];
    endcase
  endfunction

  function automatic logic [31:0] pick_time();
    case ($urandom_range(7))
      0: return $urandom_range(255);
      1: return 32'hFFFFFFFF - $urandom_range(255);
      default: return $urandom;
    endcase
  endfunction

  task automatic test_reset_state();
    // registers come up as identity with zero rate
    send_time(32'h00000000);
    send_time(32'hFFFFFFFF);
  endtask

  task automatic test_each_kind();
    set_waveform(pwg_pkg::KIND_CONSTANT, 24'h7FFFFF, 24'h800000, 32'h0, 32'h00010000);
    send_time(32'h00001234);
    // largest time sum and rate, both levels at the most negative value
    set_waveform(pwg_pkg::KIND_SQUARE, 24'h800000, 24'h800000, 32'hFFFFFFFF, 32'hFFFFFFFF);
    send_time(32'h00000000);
    send_time(32'hFFFFFFFF);
    send_time(32'h00000001);
    set_waveform(pwg_pkg::KIND_SQUARE, 24'h7FFFFF, 24'h7FFFFF, 32'h0, 32'h00010000);
    send_time(32'h00010000);
    send_time(32'h00008000);
    set_waveform(pwg_pkg::KIND_SAWTOOTH, 24'h000000, 24'h7FFFFF, 32'h0, 32'h00010000);
    send_time(32'h00000000);
    send_time(32'h00008000);
    send_time(32'h0000FFFF);
    set_waveform(pwg_pkg::KIND_TRIANGLE, 24'h800000, 24'h800000, 32'h00008000, 32'h00010000);
    send_time(32'h00000000);
    send_time(32'h00004000);
    send_time(32'h00008000);
    send_time(32'h0000C000);
    // zero rate gives 1.0 for the shaped kinds
    for (int k = pwg_pkg::KIND_SQUARE; k <= pwg_pkg::KIND_TRIANGLE; k++) begin
      set_waveform(k[pwg_pkg::KIND_W-1:0], 24'h123456, 24'h654321, 32'h00020000, 32'h0);
      send_time(32'h00012345);
    end
    // unused kinds fall back to the base level
    for (int k = pwg_pkg::KIND_TRIANGLE + 1; k <= KIND_LAST_UNUSED; k++) begin
      set_waveform(k[pwg_pkg::KIND_W-1:0], pick_level(), pick_level(), $urandom, $urandom);
      send_time($urandom);
    end
  endtask

  task automatic test_random_waves(input int sender_idle, input int receiver_stall);
    logic [pwg_pkg::KIND_W-1:0] kind;
    logic [pwg_pkg::RATE_W-1:0] rate;
    logic [pwg_pkg::TIME_W-1:0] phase;
    logic [pwg_pkg::TIME_W-1:0] t;
    logic [pwg_pkg::TIME_W-1:0] step;
    logic [31:0] pick;
    idle_pct = sender_idle;
    stall_pct = receiver_stall;
    repeat (6) begin
      pick = $urandom_range(7);
      if ($urandom_range(3) != 0) pick = pwg_pkg::KIND_SQUARE + $urandom_range(2);
      kind = pick[pwg_pkg::KIND_W-1:0];
      case ($urandom_range(7))
        0: rate = 32'h0;
        1, 2, 3: rate = $urandom_range(32'h00100000, 1);
        default: rate = $urandom;
      endcase
      case ($urandom_range(7))
        0, 1: phase = 32'h0;
        2: phase = 32'hFFFFFFFF;
        default: phase = $urandom;
      endcase
      set_waveform(kind, pick_level(), pick_level(), phase, rate);
      t = pick_time();
      step = $urandom_range(32'h00004000, 1);
      repeat (35) begin
        // half the items sweep through the cycle, half jump around
        if ($urandom_range(1) == 0) t = t + step;
        else t = pick_time();
        send_time(t);
      end
    end
  endtask

  initial begin
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_sample_time <= '0;
    cfg_we <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    kind_cfg = pwg_pkg::KIND_IDENTITY;
    base_cfg = '0;
    amp_cfg = '0;
    phase_cfg = '0;
    rate_cfg = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_state();
    test_each_kind();
    test_random_waves(0, 0);
    test_random_waves(69, 0);
    test_random_waves(0, 69);
    test_random_waves(21, 21);

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

[periodic_waveform_generator.f]
+incdir+rtl/core
rtl/core/pwg_pkg.sv
rtl/core/pwg_shape.sv
rtl/core/periodic_waveform_generator.sv
rtl/core/pwg_checker.sv
tb/sv/tb.sv
